// ===== design/sp4q_pkg.sv =====
// Shared constants, types and helpers for the strict priority four-queue block.
package sp4q_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int PACKET_BITS = 32;
    localparam int NUM_Q       = 4;
    localparam int Q_W         = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W      = Q_W + PTR_W;
    localparam int MEM_DEPTH   = NUM_Q << PTR_W;
    localparam int WORD_W      = 32;

    // Request codes
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_PUSHED  = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_POPPED  = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // One result word
    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] pkt;
        logic              cus;
        logic              trf;
    } t_result;

    // Fit an incoming word to the stored payload width
    function automatic logic [PACKET_BITS-1:0] to_store(input logic [WORD_W-1:0] p);
        logic [63:0] t;
        t = 64'(p);
        return t[PACKET_BITS-1:0];
    endfunction

    // Fit a stored payload to the result word width
    function automatic logic [WORD_W-1:0] to_out(input logic [PACKET_BITS-1:0] w);
        logic [63:0] t;
        t = 64'(w);
        return t[WORD_W-1:0];
    endfunction

endpackage

// ===== design/sp4q_req_if.sv =====
// Request channel: valid/ready handshake with push/pop request payload.
interface sp4q_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic        customer_class;
    logic        traffic_class;
    logic [31:0] packet_word;

    modport source (output valid, req_type, customer_class, traffic_class, packet_word,
                    input ready);
    modport sink   (input valid, req_type, customer_class, traffic_class, packet_word,
                    output ready);
endinterface

// ===== design/sp4q_res_if.sv =====
// Result channel: valid/ready handshake with status and popped packet.
interface sp4q_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op_status;
    logic [31:0] out_packet;
    logic        served_customer;
    logic        served_traffic;

    modport source (output valid, op_status, out_packet, served_customer, served_traffic,
                    input ready);
    modport sink   (input valid, op_status, out_packet, served_customer, served_traffic,
                    output ready);
endinterface

// ===== design/strict_priority_four_queue_core.sv =====
// Strict priority queue core: four ring FIFOs in one payload memory.
//
//  channel | dir | word contents                                         | handshake
//  i_req   | in  | req_type, customer_class, traffic_class, packet_word   | valid/ready
//  o_res   | out | op_status, out_packet, served_customer, served_traffic | valid/ready
//
// A push or an empty pop forms its result in the cycle it is accepted.
// A pop of a stored word goes through S_READ, since the payload memory read is synchronous.
// One request is in flight at a time; a result waits in the output register while
// the next request is taken, and a second result parks until the output drains.
// Reset clears pointers, fill counts and control; the payload memory is not cleared.
module strict_priority_four_queue_core
    import sp4q_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    sp4q_req_if.sink     i_req,
    sp4q_res_if.source   o_res
);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_HOLD} t_state;

    t_state r_state, n_state;

    // Per-queue pointers and fill counts
    logic [PTR_W-1:0] r_rd_ptr [NUM_Q];
    logic [PTR_W-1:0] r_wr_ptr [NUM_Q];
    logic [CNT_W-1:0] r_cnt    [NUM_Q];

    // Payload memory and its read register
    logic [PACKET_BITS-1:0] mem [MEM_DEPTH];
    logic [PACKET_BITS-1:0] r_rd_data;

    logic [Q_W-1:0] r_pop_q;
    t_result        r_out, r_pend, cand;
    logic           r_out_valid;
    logic           cand_valid;

    logic             accept, is_pop, full, any, slot_free;
    logic             do_push, do_pop;
    logic [Q_W-1:0]   push_q, pop_q;
    logic [NUM_Q-1:0] nonempty;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign is_pop      = (i_req.req_type == REQ_POP);
    assign push_q      = {i_req.customer_class, i_req.traffic_class};
    assign full        = (r_cnt[push_q] == CNT_W'(QUEUE_DEPTH));
    assign do_push     = accept && !is_pop && !full;
    assign do_pop      = accept && is_pop && any;
    assign slot_free   = !r_out_valid || o_res.ready;

    // Priority pick over non-empty queues, lowest index first
    always_comb begin
        pop_q = '0;
        any   = 1'b0;
        for (int q = 0; q < NUM_Q; q++) begin
            nonempty[q] = (r_cnt[q] != '0);
        end
        for (int q = NUM_Q - 1; q >= 0; q--) begin
            if (nonempty[q]) begin
                pop_q = Q_W'(q);
                any   = 1'b1;
            end
        end
    end

    // Pointer and fill count update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_Q; q++) begin
                r_rd_ptr[q] <= '0;
                r_wr_ptr[q] <= '0;
                r_cnt[q]    <= '0;
            end
        end else begin
            if (do_push) begin
                r_wr_ptr[push_q] <= (r_wr_ptr[push_q] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                    '0 : r_wr_ptr[push_q] + 1'b1;
                r_cnt[push_q]    <= r_cnt[push_q] + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr[pop_q] <= (r_rd_ptr[pop_q] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                   '0 : r_rd_ptr[pop_q] + 1'b1;
                r_cnt[pop_q]    <= r_cnt[pop_q] - 1'b1;
            end
        end
    end

    // Payload memory: a pop only reads entries written by earlier pushes,
    // and only one request is taken per cycle, so no read/write overlap arises
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[{push_q, r_wr_ptr[push_q]}] <= to_store(i_req.packet_word);
        end
        if (do_pop) begin
            r_rd_data <= mem[{pop_q, r_rd_ptr[pop_q]}];
            r_pop_q   <= pop_q;
        end
    end

    // Result candidate and next state
    always_comb begin
        n_state    = r_state;
        cand_valid = 1'b0;
        cand       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (is_pop && any) begin
                        n_state = S_READ;
                    end else begin
                        cand_valid = 1'b1;
                        if (is_pop) begin
                            cand.status = ST_EMPTY;
                        end else begin
                            cand.status = full ? ST_DROPPED : ST_PUSHED;
                            cand.cus    = i_req.customer_class;
                            cand.trf    = i_req.traffic_class;
                        end
                    end
                end
            end
            S_READ: begin
                cand_valid  = 1'b1;
                cand.status = ST_POPPED;
                cand.pkt    = to_out(r_rd_data);
                cand.cus    = r_pop_q[1];
                cand.trf    = r_pop_q[0];
            end
            S_HOLD: begin
                cand_valid = 1'b1;
                cand       = r_pend;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (cand_valid) begin
            n_state = slot_free ? S_IDLE : S_HOLD;
        end
    end

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cand_valid && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output and parked result payload
    always_ff @(posedge i_clk) begin
        if (cand_valid) begin
            if (slot_free) begin
                r_out <= cand;
            end else begin
                r_pend <= cand;
            end
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.op_status       = r_out.status;
    assign o_res.out_packet      = r_out.pkt;
    assign o_res.served_customer = r_out.cus;
    assign o_res.served_traffic  = r_out.trf;

endmodule

// ===== design/sp4q_checker.sv =====
// Port-level checks for the strict priority queue core, bound to the top level.
module sp4q_checker
    import sp4q_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [1:0]  i_op_status,
    input logic [31:0] i_out_packet,
    input logic        i_served_customer,
    input logic        i_served_traffic
);

    // A pending result word stays until taken
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result valid dropped while stalled");

    // A stalled result word keeps its status and packet
    a_word_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_op_status) && $stable(i_out_packet))
        else $error("result word changed while stalled");

    // Empty pop reports no packet and no queue
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_op_status == ST_EMPTY) |->
        (i_out_packet == '0) && !i_served_customer && !i_served_traffic)
        else $error("empty pop carries data");

    // Push results carry no packet
    a_push_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && ((i_op_status == ST_PUSHED) || (i_op_status == ST_DROPPED)) |->
        (i_out_packet == '0))
        else $error("push result carries data");

endmodule

bind strict_priority_four_queue_core sp4q_checker u_sp4q_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_op_status       (o_res.op_status),
    .i_out_packet      (o_res.out_packet),
    .i_served_customer (o_res.served_customer),
    .i_served_traffic  (o_res.served_traffic)
);
